[hdl/ipmi_bt_mailbox_registers_assert.svh]
// Assertion macros used by the mailbox top level.
`ifndef IPMI_BT_MAILBOX_REGISTERS_ASSERT_SVH
`define IPMI_BT_MAILBOX_REGISTERS_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define IBT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ibt assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define IBT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ibt assertion failed");

`endif

[hdl/ibt_pkg.sv]
// Shared types and constants of the BT mailbox.
package ibt_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int Q_DEPTH          = 2;

    // Access kinds on the input channel
    localparam logic [2:0] KIND_BMC_READ   = 3'd0;
    localparam logic [2:0] KIND_BMC_WRITE  = 3'd1;
    localparam logic [2:0] KIND_HOST_WRITE = 3'd2;
    localparam logic [2:0] KIND_HOST_READ  = 3'd3;
    localparam logic [2:0] KIND_HOST_CTRL  = 3'd4;

    // BMC register offsets
    localparam logic [4:0] OFF_CTRL = 5'h10;
    localparam logic [4:0] OFF_DATA = 5'h14;

    // Control byte bits
    localparam logic [7:0] CTL_B_BUSY  = 8'h80;
    localparam logic [7:0] CTL_H_BUSY  = 8'h40;
    localparam logic [7:0] CTL_OEM0    = 8'h20;
    localparam logic [7:0] CTL_SMS_ATN = 8'h10;
    localparam logic [7:0] CTL_B2H_ATN = 8'h08;
    localparam logic [7:0] CTL_H2B_ATN = 8'h04;
    localparam logic [7:0] CTL_CLR_RD  = 8'h02;
    localparam logic [7:0] CTL_CLR_WR  = 8'h01;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_HOST_IO     = 3'd1;
    localparam logic [2:0] CFG_HOST_IRQ    = 3'd2;
    localparam logic [2:0] CFG_ALLOW_CLRRD = 3'd3;
    localparam logic [2:0] CFG_ALLOW_CLRWR = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CTRL_READ,
        OP_BMC_DATA_READ,
        OP_BMC_CTRL_WRITE,
        OP_BMC_DATA_WRITE,
        OP_HOST_DATA_WRITE,
        OP_HOST_DATA_READ,
        OP_HOST_CTRL_WRITE
    } op_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_CTRL,
        SRC_H2B,
        SRC_B2H
    } src_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic enable;
        logic allow_clr_rd;
        logic allow_clr_wr;
    } cfg_t;

    typedef struct packed {
        logic b_busy;
        logic h_busy;
        logic oem0;
        logic sms_atn;
        logic b2h_atn;
        logic h2b_atn;
    } flags_t;

    function automatic logic [7:0] flags_byte(flags_t f);
        logic [7:0] b;
        b = 8'h00;
        if (f.b_busy)  b = b | CTL_B_BUSY;
        if (f.h_busy)  b = b | CTL_H_BUSY;
        if (f.oem0)    b = b | CTL_OEM0;
        if (f.sms_atn) b = b | CTL_SMS_ATN;
        if (f.b2h_atn) b = b | CTL_B2H_ATN;
        if (f.h2b_atn) b = b | CTL_H2B_ATN;
        return b;
    endfunction

endpackage

[hdl/ibt_front.sv]
// Front end: accepts access words and classifies them into mailbox operations.
module ibt_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_kind,
    input  logic [4:0]        s_reg_offset,
    input  logic [7:0]        s_write_data,
    input  ibt_pkg::cfg_t     cfg,
    input  ibt_pkg::q_status_t q_st,
    output logic              push,
    output ibt_pkg::q_entry_t push_entry
);

    ibt_pkg::op_t op;
    logic [7:0]   data;

    always_comb begin
        op   = ibt_pkg::OP_NOP;
        data = s_write_data;
        unique case (s_kind)
            ibt_pkg::KIND_BMC_READ: begin
                if (s_reg_offset == ibt_pkg::OFF_CTRL) begin
                    op = ibt_pkg::OP_CTRL_READ;
                end else if (s_reg_offset == ibt_pkg::OFF_DATA) begin
                    op = ibt_pkg::OP_BMC_DATA_READ;
                end
            end
            ibt_pkg::KIND_BMC_WRITE: begin
                if (s_reg_offset == ibt_pkg::OFF_CTRL) begin
                    op = ibt_pkg::OP_BMC_CTRL_WRITE;
                    // drop pointer clears that the configuration does not allow
                    if (!cfg.allow_clr_wr) begin
                        data = data & ~ibt_pkg::CTL_CLR_WR;
                    end
                    if (!cfg.allow_clr_rd) begin
                        data = data & ~ibt_pkg::CTL_CLR_RD;
                    end
                end else if (s_reg_offset == ibt_pkg::OFF_DATA) begin
                    op = ibt_pkg::OP_BMC_DATA_WRITE;
                end
            end
            ibt_pkg::KIND_HOST_WRITE: op = ibt_pkg::OP_HOST_DATA_WRITE;
            ibt_pkg::KIND_HOST_READ:  op = ibt_pkg::OP_HOST_DATA_READ;
            ibt_pkg::KIND_HOST_CTRL:  op = ibt_pkg::OP_HOST_CTRL_WRITE;
            default:                  op = ibt_pkg::OP_NOP;
        endcase
        if (!cfg.enable) begin
            op = ibt_pkg::OP_NOP;
        end
    end

    assign s_ready         = !q_st.full;
    assign push            = s_valid && !q_st.full;
    assign push_entry.op   = op;
    assign push_entry.data = data;

endmodule

[hdl/ibt_queue.sv]
// Two-entry queue between the classifier and the execute stage.
module ibt_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ibt_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output ibt_pkg::q_entry_t  head,
    output ibt_pkg::q_status_t q_st
);

    ibt_pkg::q_entry_t slots_reg [ibt_pkg::Q_DEPTH];
    logic              wr_idx_reg;
    logic              wr_idx_next;
    logic              rd_idx_reg;
    logic              rd_idx_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    always_comb begin
        wr_idx_next = push ? ~wr_idx_reg : wr_idx_reg;
        rd_idx_next = pop  ? ~rd_idx_reg : rd_idx_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_idx_reg] <= push_entry;
        end
    end

    assign head       = slots_reg[rd_idx_reg];
    assign q_st.empty = (count_reg == 2'd0);
    assign q_st.full  = (count_reg == 2'(ibt_pkg::Q_DEPTH));

endmodule

[hdl/ibt_back.sv]
// Back end: executes mailbox operations against flags, pointers and buffers.
module ibt_back #(
    parameter int BUFFER_DEPTH = ibt_pkg::BUFFER_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ibt_pkg::q_entry_t  head,
    input  ibt_pkg::q_status_t q_st,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_read_data,
    output logic               m_h2b_attention,
    output logic               m_b2h_attention,
    output logic               m_bmc_busy,
    output logic               m_host_busy
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

    function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    logic [7:0] h2b_mem [BUFFER_DEPTH];
    logic [7:0] b2h_mem [BUFFER_DEPTH];

    ibt_pkg::flags_t  flags_reg, flags_next;
    logic [PTR_W-1:0] bmc_rd_ptr_reg, bmc_rd_ptr_next;
    logic [PTR_W-1:0] bmc_wr_ptr_reg, bmc_wr_ptr_next;
    logic [PTR_W-1:0] host_rd_ptr_reg, host_rd_ptr_next;
    logic [PTR_W-1:0] host_wr_ptr_reg, host_wr_ptr_next;

    logic             res_valid_reg, res_valid_next;
    ibt_pkg::src_t    res_src_reg, src;
    ibt_pkg::flags_t  res_flags_reg;
    logic [7:0]       res_ctrl_reg;
    logic [7:0]       h2b_rdata_reg;
    logic [7:0]       b2h_rdata_reg;
    logic             issue;
    logic [7:0]       d;

    assign issue = !q_st.empty && (!res_valid_reg || m_ready);
    assign pop   = issue;
    assign d     = head.data;

    always_comb begin
        flags_next       = flags_reg;
        bmc_rd_ptr_next  = bmc_rd_ptr_reg;
        bmc_wr_ptr_next  = bmc_wr_ptr_reg;
        host_rd_ptr_next = host_rd_ptr_reg;
        host_wr_ptr_next = host_wr_ptr_reg;
        src              = ibt_pkg::SRC_NONE;
        unique case (head.op)
            ibt_pkg::OP_CTRL_READ: src = ibt_pkg::SRC_CTRL;
            ibt_pkg::OP_BMC_DATA_READ: begin
                src             = ibt_pkg::SRC_H2B;
                bmc_rd_ptr_next = advance(bmc_rd_ptr_reg);
            end
            ibt_pkg::OP_BMC_CTRL_WRITE: begin
                if ((d & ibt_pkg::CTL_CLR_WR) != 8'h00)  bmc_wr_ptr_next = '0;
                if ((d & ibt_pkg::CTL_CLR_RD) != 8'h00)  bmc_rd_ptr_next = '0;
                if ((d & ibt_pkg::CTL_H2B_ATN) != 8'h00) flags_next.h2b_atn = 1'b0;
                if ((d & ibt_pkg::CTL_B2H_ATN) != 8'h00) flags_next.b2h_atn = 1'b1;
                if ((d & ibt_pkg::CTL_B_BUSY) != 8'h00) begin
                    flags_next.b_busy = ~flags_reg.b_busy;
                end
            end
            ibt_pkg::OP_BMC_DATA_WRITE:  bmc_wr_ptr_next  = advance(bmc_wr_ptr_reg);
            ibt_pkg::OP_HOST_DATA_WRITE: host_wr_ptr_next = advance(host_wr_ptr_reg);
            ibt_pkg::OP_HOST_DATA_READ: begin
                src              = ibt_pkg::SRC_B2H;
                host_rd_ptr_next = advance(host_rd_ptr_reg);
            end
            ibt_pkg::OP_HOST_CTRL_WRITE: begin
                if ((d & ibt_pkg::CTL_CLR_WR) != 8'h00)  host_wr_ptr_next = '0;
                if ((d & ibt_pkg::CTL_CLR_RD) != 8'h00)  host_rd_ptr_next = '0;
                if ((d & ibt_pkg::CTL_H2B_ATN) != 8'h00) flags_next.h2b_atn = 1'b1;
                if ((d & ibt_pkg::CTL_B2H_ATN) != 8'h00) flags_next.b2h_atn = 1'b0;
                if ((d & ibt_pkg::CTL_SMS_ATN) != 8'h00) flags_next.sms_atn = 1'b0;
                if ((d & ibt_pkg::CTL_H_BUSY) != 8'h00) begin
                    flags_next.h_busy = ~flags_reg.h_busy;
                end
            end
            default: src = ibt_pkg::SRC_NONE;
        endcase
    end

    always_comb begin
        if (issue) begin
            res_valid_next = 1'b1;
        end else if (m_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg       <= '0;
            bmc_rd_ptr_reg  <= '0;
            bmc_wr_ptr_reg  <= '0;
            host_rd_ptr_reg <= '0;
            host_wr_ptr_reg <= '0;
            res_valid_reg   <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (issue) begin
                flags_reg       <= flags_next;
                bmc_rd_ptr_reg  <= bmc_rd_ptr_next;
                bmc_wr_ptr_reg  <= bmc_wr_ptr_next;
                host_rd_ptr_reg <= host_rd_ptr_next;
                host_wr_ptr_reg <= host_wr_ptr_next;
            end
        end
    end

    // result payload: hold while the consumer stalls
    always_ff @(posedge aclk) begin
        if (issue) begin
            res_src_reg   <= src;
            res_flags_reg <= flags_next;
            res_ctrl_reg  <= ibt_pkg::flags_byte(flags_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (issue && head.op == ibt_pkg::OP_HOST_DATA_WRITE) begin
            h2b_mem[host_wr_ptr_reg] <= d;
        end
        if (issue && head.op == ibt_pkg::OP_BMC_DATA_READ) begin
            h2b_rdata_reg <= h2b_mem[bmc_rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue && head.op == ibt_pkg::OP_BMC_DATA_WRITE) begin
            b2h_mem[bmc_wr_ptr_reg] <= d;
        end
        if (issue && head.op == ibt_pkg::OP_HOST_DATA_READ) begin
            b2h_rdata_reg <= b2h_mem[host_rd_ptr_reg];
        end
    end

    always_comb begin
        case (res_src_reg)
            ibt_pkg::SRC_CTRL: m_read_data = res_ctrl_reg;
            ibt_pkg::SRC_H2B:  m_read_data = h2b_rdata_reg;
            ibt_pkg::SRC_B2H:  m_read_data = b2h_rdata_reg;
            default:           m_read_data = 8'h00;
        endcase
    end

    assign m_valid         = res_valid_reg;
    assign m_h2b_attention = res_flags_reg.h2b_atn;
    assign m_b2h_attention = res_flags_reg.b2h_atn;
    assign m_bmc_busy      = res_flags_reg.b_busy;
    assign m_host_busy     = res_flags_reg.h_busy;

endmodule

[hdl/ipmi_bt_mailbox_registers.sv]
// Top level of the BMC-side IPMI block-transfer mailbox.
// The block takes one register access word per cycle while the queue is not full and returns
// one result word per access, in order. An accepted word is classified at once and placed in
// a two-entry queue; the execute stage pops one word per cycle while the consumer does not
// stall, updates flags and pointers, writes or reads one buffer entry for a data access, and
// registers the result, so a result passes through the queue and the result register, and
// the sustained rate is one word per cycle when nothing stalls. Results wait in the output
// register while the consumer stalls; the queue keeps taking words until it is full. The
// buffers have no reset: reading an entry that was never written returns an undefined byte.
// Configuration writes are taken every cycle and must only happen while no access is in flight.
`include "ipmi_bt_mailbox_registers_assert.svh"

module ipmi_bt_mailbox_registers #(
    parameter int BUFFER_DEPTH = ibt_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // access words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [4:0]  s_reg_offset,
    input  logic [7:0]  s_write_data,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_h2b_attention,
    output logic        m_b2h_attention,
    output logic        m_bmc_busy,
    output logic        m_host_busy,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        enable_reg;
    logic [15:0] host_io_base_reg;
    logic [3:0]  host_irq_line_reg;
    logic        allow_clr_rd_reg;
    logic        allow_clr_wr_reg;

    ibt_pkg::cfg_t      cfg;
    ibt_pkg::q_status_t q_st;
    ibt_pkg::q_entry_t  push_entry;
    ibt_pkg::q_entry_t  head;
    logic               push;
    logic               pop;

    assign cfg_ready = 1'b1;

    // Configuration registers; the host base and interrupt number are only stored
    // and do not affect mailbox behavior.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg        <= 1'b0;
            host_io_base_reg  <= 16'h0000;
            host_irq_line_reg <= 4'h0;
            allow_clr_rd_reg  <= 1'b0;
            allow_clr_wr_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ibt_pkg::CFG_ENABLE:      enable_reg        <= cfg_data[0];
                ibt_pkg::CFG_HOST_IO:     host_io_base_reg  <= cfg_data;
                ibt_pkg::CFG_HOST_IRQ:    host_irq_line_reg <= cfg_data[3:0];
                ibt_pkg::CFG_ALLOW_CLRRD: allow_clr_rd_reg  <= cfg_data[0];
                ibt_pkg::CFG_ALLOW_CLRWR: allow_clr_wr_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.enable       = enable_reg;
    assign cfg.allow_clr_rd = allow_clr_rd_reg;
    assign cfg.allow_clr_wr = allow_clr_wr_reg;

    ibt_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_reg_offset (s_reg_offset),
        .s_write_data (s_write_data),
        .cfg          (cfg),
        .q_st         (q_st),
        .push         (push),
        .push_entry   (push_entry)
    );

    ibt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_st       (q_st)
    );

    ibt_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .q_st            (q_st),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_h2b_attention (m_h2b_attention),
        .m_b2h_attention (m_b2h_attention),
        .m_bmc_busy      (m_bmc_busy),
        .m_host_busy     (m_host_busy)
    );

    // The queue can never report full and empty together.
    `IBT_ASSERT_IMPL(a_q_consistent, aclk, aresetn, q_st.full, !q_st.empty)
    // A word that finds the pipeline idle produces its result after passing the queue and the result register.
    `IBT_ASSERT_NEXT(a_idle_latency, aclk, aresetn, s_valid && s_ready && q_st.empty && !m_valid, ##1 m_valid)
    // Nothing is popped from an empty queue.
    `IBT_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, !q_st.empty)

endmodule
